>>> hdl/dsol_pkg.sv
`default_nettype none

package dsol_pkg;

  localparam int unsigned IdW  = 5;
  localparam int unsigned KeyW = 8;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_REPOS    = 2'd2,
    OP_READ_OUT = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_PRESENT = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef struct packed {
    opcode_e          opcode;
    logic [IdW-1:0]   object_id;
    logic [KeyW-1:0]  depth_key;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0]   result_object;
    logic [KeyW-1:0]  result_key;
    status_e          status;
    logic             last;
  } out_item_t;

  // Read address source for the link and key memories
  typedef enum logic [1:0] {
    RD_HOLD = 2'd0,
    RD_HEAD = 2'd1,
    RD_ID   = 2'd2,
    RD_NEXT = 2'd3
  } rd_sel_e;

  // Content loaded into the pending result
  typedef enum logic [2:0] {
    RES_ABSENT   = 3'd0,
    RES_EMPTY    = 3'd1,
    RES_DUP      = 3'd2,
    RES_REMOVED  = 3'd3,
    RES_INSERTED = 3'd4
  } res_sel_e;

  typedef enum logic {
    OUT_RES  = 1'b0,
    OUT_WALK = 1'b1
  } out_src_e;

  typedef struct packed {
    logic      load_in;
    rd_sel_e   rd_sel;
    logic      res_load;
    res_sel_e  res_sel;
    logic      out_load;
    out_src_e  out_src;
    logic      ins_write;
    logic      ins_link;
    logic      rem_unlink;
  } ctl_cmd_t;

  typedef struct packed {
    opcode_e  opcode;
    logic     id_ok;
    logic     in_list_hit;
    logic     count_zero;
    logic     walk_end;
    logic     key_ge;
    logic     cur_is_id;
    logic     is_last;
    logic     out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hdl/depth_sorted_object_list_unit.sv
`default_nettype none

// Channel  Signals                               Moves
// -------  ------------------------------------  ---------------------------------
// in       in_valid_i, in_ready_o, in_item_i     opcode, object_id, depth_key
// out      out_valid_o, out_ready_i, out_item_o  result_object, result_key, status,
//                                                last
//
// One command at a time; the list walk reads one entry per cycle from the link
// and key memories while it is not stalled. Reset clears the membership bits,
// head and count at once; links and keys need no clearing pass. The output
// register frees the input side while a result waits; a stalled read-out holds
// its walk position.

module depth_sorted_object_list_unit #(
  parameter int unsigned MAX_OBJECTS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire dsol_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output dsol_pkg::out_item_t      out_item_o
);

  dsol_pkg::ctl_cmd_t   cmd;
  dsol_pkg::dp_status_t status;

  dsol_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dsol_dp #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // One command in flight: no transfer in the cycle after one
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a command is in flight");

  // Never overwrite a result that waits on the output
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> status.out_free)
    else $error("output register overwritten");

  // Unlink only at the entry of the addressed object
  a_unlink_at_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rem_unlink |-> status.cur_is_id)
    else $error("unlink at wrong entry");

  // Link in only an object that is not listed
  a_no_dup_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins_write |-> !status.in_list_hit)
    else $error("object linked in twice");

endmodule

`default_nettype wire

>>> hdl/dsol_ram.sv
`default_nettype none

module dsol_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(Depth)-1:0]   waddr_i,
  input  wire logic [Width-1:0]           wdata_i,
  input  wire logic [$clog2(Depth)-1:0]   raddr_i,
  output logic      [Width-1:0]           rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/dsol_ctrl.sv
`default_nettype none

module dsol_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire dsol_pkg::dp_status_t status_i,
  output dsol_pkg::ctl_cmd_t        cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DUP,
    S_REM_WALK,
    S_INS_START,
    S_INS_WALK,
    S_INS_LINK,
    S_RD_WALK,
    S_RESULT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Decode the state into datapath commands and pick the next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status_i.opcode == dsol_pkg::OP_READ_OUT) begin
          if (status_i.count_zero) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = dsol_pkg::RES_EMPTY;
            state_d        = S_RESULT;
          end else begin
            cmd_o.rd_sel = dsol_pkg::RD_HEAD;
            state_d      = S_RD_WALK;
          end
        end else if (!status_i.id_ok) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = dsol_pkg::RES_ABSENT;
          state_d        = S_RESULT;
        end else if (status_i.opcode == dsol_pkg::OP_INSERT) begin
          if (status_i.in_list_hit) begin
            cmd_o.rd_sel = dsol_pkg::RD_ID;
            state_d      = S_DUP;
          end else begin
            cmd_o.rd_sel = dsol_pkg::RD_HEAD;
            state_d      = S_INS_WALK;
          end
        end else if (status_i.opcode == dsol_pkg::OP_REMOVE) begin
          if (status_i.in_list_hit) begin
            cmd_o.rd_sel = dsol_pkg::RD_HEAD;
            state_d      = S_REM_WALK;
          end else begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = dsol_pkg::RES_ABSENT;
            state_d        = S_RESULT;
          end
        end else begin
          // Reposition: unlink first when listed, then link in
          cmd_o.rd_sel = dsol_pkg::RD_HEAD;
          state_d      = status_i.in_list_hit ? S_REM_WALK : S_INS_WALK;
        end
      end
      S_DUP: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = dsol_pkg::RES_DUP;
        state_d        = S_RESULT;
      end
      S_REM_WALK: begin
        if (status_i.cur_is_id) begin
          cmd_o.rem_unlink = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_sel    = dsol_pkg::RES_REMOVED;
          state_d = (status_i.opcode == dsol_pkg::OP_REMOVE) ? S_RESULT : S_INS_START;
        end else begin
          cmd_o.rd_sel = dsol_pkg::RD_NEXT;
        end
      end
      S_INS_START: begin
        cmd_o.rd_sel = dsol_pkg::RD_HEAD;
        state_d      = S_INS_WALK;
      end
      S_INS_WALK: begin
        if (status_i.walk_end || status_i.key_ge) begin
          cmd_o.ins_write = 1'b1;
          state_d         = S_INS_LINK;
        end else begin
          cmd_o.rd_sel = dsol_pkg::RD_NEXT;
        end
      end
      S_INS_LINK: begin
        cmd_o.ins_link = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = dsol_pkg::RES_INSERTED;
        state_d        = S_RESULT;
      end
      S_RD_WALK: begin
        // Emit one entry per free output slot, hold the read on a stall
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_src  = dsol_pkg::OUT_WALK;
          if (status_i.is_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_sel = dsol_pkg::RD_NEXT;
          end
        end
      end
      S_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_src  = dsol_pkg::OUT_RES;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/dsol_dp.sv
`default_nettype none

module dsol_dp #(
  parameter int unsigned MAX_OBJECTS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dsol_pkg::in_item_t   in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output dsol_pkg::out_item_t       out_item_o,
  input  wire dsol_pkg::ctl_cmd_t   cmd_i,
  output dsol_pkg::dp_status_t      status_o
);

  localparam int unsigned IdxW = $clog2(MAX_OBJECTS);
  localparam int unsigned CntW = $clog2(MAX_OBJECTS + 1);

  dsol_pkg::in_item_t  in_q;
  dsol_pkg::out_item_t res_q, res_d;
  dsol_pkg::out_item_t out_q, out_d;
  logic                out_valid_q;

  logic                   was_q;
  logic [IdxW-1:0]        head_q, head_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [MAX_OBJECTS-1:0] in_list_q, in_list_d;

  // Walker: cur_q is the address whose data the memories now show
  logic [IdxW-1:0] cur_q, cur_d;
  logic [IdxW-1:0] prev_q, prev_d;
  logic            has_prev_q, has_prev_d;
  logic [CntW-1:0] step_q, step_d;

  logic [IdxW-1:0]           idx;
  logic [dsol_pkg::KeyW-1:0] key_rd;
  logic [IdxW-1:0]           link_rd;
  logic                      link_we;
  logic [IdxW-1:0]           link_waddr;
  logic [IdxW-1:0]           link_wdata;
  logic                      out_free;
  logic                      is_last;

  assign idx      = IdxW'(in_q.object_id);
  assign out_free = !out_valid_q || out_ready_i;
  assign is_last  = (CntW'(step_q + 1'b1) == count_q);

  dsol_ram #(
    .Width (dsol_pkg::KeyW),
    .Depth (MAX_OBJECTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ins_write),
    .waddr_i (idx),
    .wdata_i (in_q.depth_key),
    .raddr_i (cur_d),
    .rdata_o (key_rd)
  );

  // Link writes: new entry's successor, predecessor on link-in or unlink
  assign link_we    = cmd_i.ins_write || ((cmd_i.ins_link || cmd_i.rem_unlink) && has_prev_q);
  assign link_waddr = cmd_i.ins_write ? idx : prev_q;
  assign link_wdata = cmd_i.ins_write ? cur_q : (cmd_i.ins_link ? idx : link_rd);

  dsol_ram #(
    .Width (IdxW),
    .Depth (MAX_OBJECTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (cur_d),
    .rdata_o (link_rd)
  );

  // Advance the walker
  always_comb begin
    cur_d      = cur_q;
    prev_d     = prev_q;
    has_prev_d = has_prev_q;
    step_d     = step_q;
    case (cmd_i.rd_sel)
      dsol_pkg::RD_HEAD: begin
        cur_d      = head_q;
        prev_d     = '0;
        has_prev_d = 1'b0;
        step_d     = '0;
      end
      dsol_pkg::RD_ID: begin
        cur_d = idx;
      end
      dsol_pkg::RD_NEXT: begin
        cur_d      = link_rd;
        prev_d     = cur_q;
        has_prev_d = 1'b1;
        step_d     = CntW'(step_q + 1'b1);
      end
      default: begin
        cur_d = cur_q;
      end
    endcase
  end

  // Update head, count and membership
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    in_list_d = in_list_q;
    if (cmd_i.ins_write) begin
      in_list_d[idx] = 1'b1;
    end
    if (cmd_i.ins_link) begin
      count_d = CntW'(count_q + 1'b1);
      if (!has_prev_q) begin
        head_d = idx;
      end
    end
    if (cmd_i.rem_unlink) begin
      in_list_d[idx] = 1'b0;
      count_d        = CntW'(count_q - 1'b1);
      if (count_q == CntW'(1)) begin
        head_d = '0;
      end else if (!has_prev_q) begin
        head_d = link_rd;
      end
    end
  end

  // Build the pending single result
  always_comb begin
    res_d               = res_q;
    res_d.result_object = in_q.object_id;
    res_d.last          = 1'b1;
    case (cmd_i.res_sel)
      dsol_pkg::RES_ABSENT: begin
        res_d.result_key = '0;
        res_d.status     = dsol_pkg::ST_ABSENT;
      end
      dsol_pkg::RES_EMPTY: begin
        res_d.result_object = '0;
        res_d.result_key    = '0;
        res_d.status        = dsol_pkg::ST_EMPTY;
      end
      dsol_pkg::RES_DUP: begin
        res_d.result_key = key_rd;
        res_d.status     = dsol_pkg::ST_PRESENT;
      end
      dsol_pkg::RES_REMOVED: begin
        res_d.result_key = key_rd;
        res_d.status     = dsol_pkg::ST_OK;
      end
      dsol_pkg::RES_INSERTED: begin
        res_d.result_key = in_q.depth_key;
        res_d.status     = ((in_q.opcode == dsol_pkg::OP_REPOS) && !was_q) ?
                           dsol_pkg::ST_ABSENT : dsol_pkg::ST_OK;
      end
      default: begin
        res_d = res_q;
      end
    endcase
  end

  // Select the next output item
  always_comb begin
    if (cmd_i.out_src == dsol_pkg::OUT_WALK) begin
      out_d.result_object = dsol_pkg::IdW'(cur_q);
      out_d.result_key    = key_rd;
      out_d.status        = dsol_pkg::ST_OK;
      out_d.last          = is_last;
    end else begin
      out_d = res_q;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_q       <= 1'b0;
      head_q      <= '0;
      count_q     <= '0;
      in_list_q   <= '0;
      cur_q       <= '0;
      prev_q      <= '0;
      has_prev_q  <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q     <= head_d;
      count_q    <= count_d;
      in_list_q  <= in_list_d;
      cur_q      <= cur_d;
      prev_q     <= prev_d;
      has_prev_q <= has_prev_d;
      step_q     <= step_d;
      if (cmd_i.load_in) begin
        was_q <= 1'b0;
      end else if (status_o.opcode == dsol_pkg::OP_REPOS && cmd_i.rem_unlink) begin
        was_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_item_i;
    end
    if (cmd_i.res_load) begin
      res_q <= res_d;
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign status_o.opcode      = in_q.opcode;
  assign status_o.id_ok       = (int'(in_q.object_id) < MAX_OBJECTS);
  assign status_o.in_list_hit = in_list_q[idx];
  assign status_o.count_zero  = (count_q == '0);
  assign status_o.walk_end    = (step_q == count_q);
  assign status_o.key_ge      = (key_rd >= in_q.depth_key);
  assign status_o.cur_is_id   = (cur_q == idx);
  assign status_o.is_last     = is_last;
  assign status_o.out_free    = out_free;

endmodule

`default_nettype wire
